@@ rtl/core/btlv_pkg.sv @@
package btlv_pkg;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int NUM_ALIAS_TAGS   = 4;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [4:0] TAG_MORE_MASK = 5'h1F;

    // configuration register indexes
    localparam logic [2:0] REG_MATCH_TAG_0     = 3'd0;
    localparam logic [2:0] REG_MATCH_TAG_1     = 3'd1;
    localparam logic [2:0] REG_MATCH_TAG_2     = 3'd2;
    localparam logic [2:0] REG_MATCH_TAG_3     = 3'd3;
    localparam logic [2:0] REG_MATCH_TAG_COUNT = 3'd4;

    localparam logic [2:0] MATCH_TAG_COUNT_RESET = 3'd1;

    // result kinds
    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // summary status codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_MALFORMED = 2'd3;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] element_tag;
        logic [31:0] value_length;
        logic [15:0] element_offset;
        logic [15:0] value_offset;
        logic        tag_matched;
        logic [1:0]  scan_status;
        logic        last_result;
    } btlv_result_t;

endpackage

@@ rtl/core/btlv_parser.sv @@
module btlv_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_buffer,
    input  logic                  cfg_fire,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output logic                  el_valid,
    output btlv_pkg::btlv_result_t el_result,
    output logic                  sum_valid,
    output btlv_pkg::btlv_result_t sum_result
);
    import btlv_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG1,
        PH_TAG2,
        PH_LEN1,
        PH_LENX,
        PH_VALUE,
        PH_BAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  lbl_reg, lbl_next;
    logic [31:0] vleft_reg, vleft_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] hstart_reg, hstart_next;
    logic [15:0] vstart_reg, vstart_next;
    logic        seen_reg, seen_next;
    logic [15:0] fm_tag_reg, fm_tag_next;
    logic [31:0] fm_len_reg, fm_len_next;
    logic [15:0] fm_hdr_reg, fm_hdr_next;
    logic [15:0] fm_val_reg, fm_val_next;

    logic [15:0] alias_reg [NUM_ALIAS_TAGS];
    logic [2:0]  alias_cnt_reg;

    logic [2:0]  alias_cnt_eff;
    logic        hit;
    logic        done;
    logic [6:0]  len_count;

    assign alias_cnt_eff = (alias_cnt_reg > 3'(NUM_ALIAS_TAGS)) ? 3'(NUM_ALIAS_TAGS)
                                                                : alias_cnt_reg;
    assign len_count = data_byte[6:0];

    always_comb begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        lbl_next    = lbl_reg;
        vleft_next  = vleft_reg;
        pos_next    = pos_reg + 16'd1;
        hstart_next = hstart_reg;
        vstart_next = vstart_reg;
        seen_next   = seen_reg;
        fm_tag_next = fm_tag_reg;
        fm_len_next = fm_len_reg;
        fm_hdr_next = fm_hdr_reg;
        fm_val_next = fm_val_reg;
        done        = 1'b0;

        case (phase_reg)
            PH_TAG1: begin
                hstart_next = pos_reg;
                tag_next    = {8'h00, data_byte};
                phase_next  = (data_byte[4:0] == TAG_MORE_MASK) ? PH_TAG2 : PH_LEN1;
            end
            PH_TAG2: begin
                tag_next   = {tag_reg[7:0], data_byte};
                phase_next = PH_LEN1;
            end
            PH_LEN1: begin
                if (data_byte[7]) begin
                    len_next = '0;
                    if (len_count > 7'(MAX_LENGTH_BYTES)) begin
                        phase_next = PH_BAD;
                    end else if (len_count == 7'd0) begin
                        vstart_next = pos_reg + 16'd1;
                        done        = 1'b1;
                    end else begin
                        lbl_next   = len_count[2:0];
                        phase_next = PH_LENX;
                    end
                end else begin
                    len_next    = {24'h0, data_byte};
                    vstart_next = pos_reg + 16'd1;
                    if (data_byte == 8'h00) begin
                        done = 1'b1;
                    end else begin
                        vleft_next = {24'h0, data_byte};
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_LENX: begin
                len_next = {len_reg[23:0], data_byte};
                lbl_next = lbl_reg - 3'd1;
                if (lbl_reg == 3'd1) begin
                    vstart_next = pos_reg + 16'd1;
                    if (len_next == 32'd0) begin
                        done = 1'b1;
                    end else begin
                        vleft_next = len_next;
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                vleft_next = vleft_reg - 32'd1;
                if (vleft_reg == 32'd1) begin
                    done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        hit = 1'b0;
        for (int i = 0; i < NUM_ALIAS_TAGS; i++) begin
            if ((3'(i) < alias_cnt_eff) && (alias_reg[i] == tag_next)) begin
                hit = 1'b1;
            end
        end

        el_valid                 = in_fire && done;
        el_result.result_kind    = KIND_ELEMENT;
        el_result.element_tag    = tag_next;
        el_result.value_length   = len_next;
        el_result.element_offset = hstart_next;
        el_result.value_offset   = vstart_next;
        el_result.tag_matched    = hit;
        el_result.scan_status    = STATUS_FOUND;
        el_result.last_result    = !end_of_buffer;

        if (done) begin
            phase_next = PH_TAG1;
            if (hit && !seen_reg) begin
                seen_next   = 1'b1;
                fm_tag_next = tag_next;
                fm_len_next = len_next;
                fm_hdr_next = hstart_next;
                fm_val_next = vstart_next;
            end
        end

        sum_valid              = in_fire && end_of_buffer;
        sum_result.result_kind = KIND_SUMMARY;
        sum_result.last_result = 1'b1;
        if (seen_next) begin
            sum_result.element_tag    = fm_tag_next;
            sum_result.value_length   = fm_len_next;
            sum_result.element_offset = fm_hdr_next;
            sum_result.value_offset   = fm_val_next;
            sum_result.tag_matched    = 1'b1;
            sum_result.scan_status    = STATUS_FOUND;
        end else begin
            sum_result.element_tag    = '0;
            sum_result.value_length   = '0;
            sum_result.element_offset = '0;
            sum_result.value_offset   = '0;
            sum_result.tag_matched    = 1'b0;
            if (phase_next == PH_BAD) begin
                sum_result.scan_status = STATUS_MALFORMED;
            end else if (phase_next != PH_TAG1) begin
                sum_result.scan_status = STATUS_TRUNCATED;
            end else begin
                sum_result.scan_status = STATUS_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && end_of_buffer)) begin
            phase_reg  <= PH_TAG1;
            tag_reg    <= '0;
            len_reg    <= '0;
            lbl_reg    <= '0;
            vleft_reg  <= '0;
            pos_reg    <= '0;
            hstart_reg <= '0;
            vstart_reg <= '0;
            seen_reg   <= 1'b0;
            fm_tag_reg <= '0;
            fm_len_reg <= '0;
            fm_hdr_reg <= '0;
            fm_val_reg <= '0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            lbl_reg    <= lbl_next;
            vleft_reg  <= vleft_next;
            pos_reg    <= pos_next;
            hstart_reg <= hstart_next;
            vstart_reg <= vstart_next;
            seen_reg   <= seen_next;
            fm_tag_reg <= fm_tag_next;
            fm_len_reg <= fm_len_next;
            fm_hdr_reg <= fm_hdr_next;
            fm_val_reg <= fm_val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ALIAS_TAGS; i++) begin
                alias_reg[i] <= '0;
            end
            alias_cnt_reg <= MATCH_TAG_COUNT_RESET;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_MATCH_TAG_0, REG_MATCH_TAG_1,
                REG_MATCH_TAG_2, REG_MATCH_TAG_3: begin
                    alias_reg[cfg_index[1:0]] <= cfg_data;
                end
                REG_MATCH_TAG_COUNT: begin
                    alias_cnt_reg <= cfg_data[2:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/btlv_result_fifo.sv @@
module btlv_result_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr0_valid,
    input  btlv_pkg::btlv_result_t wr0_data,
    input  logic                   wr1_valid,
    input  btlv_pkg::btlv_result_t wr1_data,
    output logic                   room_for_two,
    output logic                   rd_valid,
    input  logic                   rd_ready,
    output btlv_pkg::btlv_result_t rd_data
);
    import btlv_pkg::*;

    btlv_result_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg, rptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] wr1_addr;
    logic [FIFO_CNT_W-1:0] push_n;
    logic                  pop;

    assign rd_valid     = (count_reg != '0);
    assign rd_data      = mem_reg[rptr_reg];
    assign room_for_two = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop          = rd_valid && rd_ready;
    assign wr1_addr     = wptr_reg + FIFO_PTR_W'(wr0_valid);
    assign push_n       = FIFO_CNT_W'(wr0_valid) + FIFO_CNT_W'(wr1_valid);

    always_ff @(posedge aclk) begin
        if (wr0_valid) begin
            mem_reg[wptr_reg] <= wr0_data;
        end
        if (wr1_valid) begin
            mem_reg[wr1_addr] <= wr1_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_reg + FIFO_PTR_W'(push_n);
            rptr_reg  <= rptr_reg + FIFO_PTR_W'(pop);
            count_reg <= count_reg + push_n - FIFO_CNT_W'(pop);
        end
    end

endmodule

@@ rtl/core/ber_tlv_scanner_tag_finder.sv @@
// BER-TLV top-level element scanner with alias tag search.
// Input channel (s_*): one buffer byte per transaction; s_end_of_buffer marks
// the final byte of a buffer, after which offsets restart at zero.
// Result channel (m_*): one result per transaction. A byte that completes an
// element gives an element result; the final byte also gives a summary
// (found / not found / truncated / malformed). m_last_result marks the last
// result caused by a byte.
// Config channel (cfg_*): cfg_index 0..3 write alias tags, 4 writes the alias
// count. cfg_ready is always high; writes take effect on the next byte.
// A byte's results are registered in the result queue before they reach m_*.
// Throughput: one byte per cycle while s_ready is high. The byte is decoded
// in the accepting cycle and its results are written into a four-entry result
// queue; s_ready is high while the queue has room for two results, so the
// input keeps flowing while up to two results wait on a stalled receiver.
// Bytes that cause two results are read out as two result transactions.
// Reset clears the scan state and the queue, alias tags to zero and the
// alias count to one.
module ber_tlv_scanner_tag_finder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [15:0] m_element_tag,
    output logic [31:0] m_value_length,
    output logic [15:0] m_element_offset,
    output logic [15:0] m_value_offset,
    output logic        m_tag_matched,
    output logic [1:0]  m_scan_status,
    output logic        m_last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import btlv_pkg::*;

    logic         in_fire;
    logic         el_valid;
    logic         sum_valid;
    btlv_result_t el_result;
    btlv_result_t sum_result;
    btlv_result_t out_result;
    logic         room_for_two;

    assign cfg_ready = 1'b1;
    assign s_ready   = room_for_two;
    assign in_fire   = s_valid && s_ready;

    btlv_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .data_byte     (s_data_byte),
        .end_of_buffer (s_end_of_buffer),
        .cfg_fire      (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .el_valid      (el_valid),
        .el_result     (el_result),
        .sum_valid     (sum_valid),
        .sum_result    (sum_result)
    );

    btlv_result_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr0_valid    (el_valid),
        .wr0_data     (el_result),
        .wr1_valid    (sum_valid),
        .wr1_data     (sum_result),
        .room_for_two (room_for_two),
        .rd_valid     (m_valid),
        .rd_ready     (m_ready),
        .rd_data      (out_result)
    );

    assign m_result_kind    = out_result.result_kind;
    assign m_element_tag    = out_result.element_tag;
    assign m_value_length   = out_result.value_length;
    assign m_element_offset = out_result.element_offset;
    assign m_value_offset   = out_result.value_offset;
    assign m_tag_matched    = out_result.tag_matched;
    assign m_scan_status    = out_result.scan_status;
    assign m_last_result    = out_result.last_result;

endmodule

@@ rtl/core/btlv_checker.sv @@
module btlv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic [15:0] m_element_tag,
    input logic        m_tag_matched,
    input logic [1:0]  m_scan_status,
    input logic        m_last_result
);
    import btlv_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element_tag))
        else $error("stalled result dropped or changed");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_SUMMARY) |-> m_last_result)
        else $error("summary not marked last");

    a_element_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_ELEMENT) |-> (m_scan_status == STATUS_FOUND))
        else $error("element result with nonzero status");

    a_summary_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_SUMMARY)
            |-> (m_tag_matched == (m_scan_status == STATUS_FOUND)))
        else $error("summary match flag disagrees with status");

endmodule

bind ber_tlv_scanner_tag_finder btlv_checker u_btlv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_element_tag (m_element_tag),
    .m_tag_matched (m_tag_matched),
    .m_scan_status (m_scan_status),
    .m_last_result (m_last_result)
);

@@ verif/btlv_scan_checker.sv @@
module btlv_scan_checker
    import btlv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_result_kind,
    input  logic [15:0] m_element_tag,
    input  logic [31:0] m_value_length,
    input  logic [15:0] m_element_offset,
    input  logic [15:0] m_value_offset,
    input  logic        m_tag_matched,
    input  logic [1:0]  m_scan_status,
    input  logic        m_last_result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          elements_seen,
    output int          alias_hits,
    output int          summaries_seen,
    output logic [3:0]  statuses_seen
);

    typedef enum logic [2:0] {
        SCAN_TAG_FIRST,
        SCAN_TAG_SECOND,
        SCAN_LEN_FIRST,
        SCAN_LEN_MORE,
        SCAN_VALUE,
        SCAN_DEAD
    } scan_phase_e;

    logic [15:0]  alias_tags [4];
    logic [2:0]   alias_count;

    scan_phase_e  phase;
    logic [15:0]  tag_acc;
    logic [31:0]  len_acc;
    logic [2:0]   len_left;
    logic [31:0]  val_left;
    logic [15:0]  byte_pos;
    logic [15:0]  hdr_start;
    logic [15:0]  val_start;
    logic         have_match;
    logic [15:0]  fm_tag;
    logic [31:0]  fm_len;
    logic [15:0]  fm_hdr;
    logic [15:0]  fm_val;

    btlv_result_t expected_results [$];

    task automatic note_mismatch(input string what);
        errors++;
        if (errors <= 50) begin
            $display("mismatch %0d at %0t: %s", errors, $time, what);
        end
    endtask

    task automatic clear_scan();
        phase      = SCAN_TAG_FIRST;
        tag_acc    = '0;
        len_acc    = '0;
        len_left   = '0;
        val_left   = '0;
        byte_pos   = '0;
        hdr_start  = '0;
        val_start  = '0;
        have_match = 1'b0;
        fm_tag     = '0;
        fm_len     = '0;
        fm_hdr     = '0;
        fm_val     = '0;
    endtask

    function automatic logic is_alias(input logic [15:0] t);
        int n;
        int i;
        n = (alias_count > NUM_ALIAS_TAGS) ? NUM_ALIAS_TAGS : int'(alias_count);
        for (i = 0; i < n; i++) begin
            if (alias_tags[i] == t) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic eob);
        logic [15:0]  nxt;
        logic         done;
        btlv_result_t r;
        nxt  = byte_pos + 16'd1;
        done = 1'b0;
        case (phase)
            SCAN_TAG_FIRST: begin
                hdr_start = byte_pos;
                tag_acc   = {8'h00, b};
                phase     = (b[4:0] == TAG_MORE_MASK) ? SCAN_TAG_SECOND : SCAN_LEN_FIRST;
            end
            SCAN_TAG_SECOND: begin
                tag_acc = {tag_acc[7:0], b};
                phase   = SCAN_LEN_FIRST;
            end
            SCAN_LEN_FIRST: begin
                if (b[7]) begin
                    len_acc = '0;
                    if (b[6:0] > MAX_LENGTH_BYTES) begin
                        phase = SCAN_DEAD;
                    end else if (b[6:0] == 7'd0) begin
                        val_start = nxt;
                        done      = 1'b1;
                    end else begin
                        len_left = b[2:0];
                        phase    = SCAN_LEN_MORE;
                    end
                end else begin
                    len_acc   = {24'h0, b};
                    val_start = nxt;
                    if (b == 8'h00) begin
                        done = 1'b1;
                    end else begin
                        val_left = {24'h0, b};
                        phase    = SCAN_VALUE;
                    end
                end
            end
            SCAN_LEN_MORE: begin
                len_acc  = {len_acc[23:0], b};
                len_left = len_left - 3'd1;
                if (len_left == 3'd0) begin
                    val_start = nxt;
                    if (len_acc == 32'd0) begin
                        done = 1'b1;
                    end else begin
                        val_left = len_acc;
                        phase    = SCAN_VALUE;
                    end
                end
            end
            SCAN_VALUE: begin
                val_left = val_left - 32'd1;
                if (val_left == 32'd0) done = 1'b1;
            end
            default: ;
        endcase
        byte_pos = nxt;

        if (done) begin
            r                = '0;
            r.result_kind    = KIND_ELEMENT;
            r.element_tag    = tag_acc;
            r.value_length   = len_acc;
            r.element_offset = hdr_start;
            r.value_offset   = val_start;
            r.tag_matched    = is_alias(tag_acc);
            r.scan_status    = STATUS_FOUND;
            r.last_result    = !eob;
            if (r.tag_matched && !have_match) begin
                have_match = 1'b1;
                fm_tag     = tag_acc;
                fm_len     = len_acc;
                fm_hdr     = hdr_start;
                fm_val     = val_start;
            end
            phase = SCAN_TAG_FIRST;
            expected_results.push_back(r);
        end

        if (eob) begin
            r             = '0;
            r.result_kind = KIND_SUMMARY;
            r.last_result = 1'b1;
            if (have_match) begin
                r.element_tag    = fm_tag;
                r.value_length   = fm_len;
                r.element_offset = fm_hdr;
                r.value_offset   = fm_val;
                r.tag_matched    = 1'b1;
                r.scan_status    = STATUS_FOUND;
            end else if (phase == SCAN_DEAD) begin
                r.scan_status = STATUS_MALFORMED;
            end else if (phase != SCAN_TAG_FIRST) begin
                r.scan_status = STATUS_TRUNCATED;
            end else begin
                r.scan_status = STATUS_NOT_FOUND;
            end
            expected_results.push_back(r);
            clear_scan();
        end
    endtask

    task automatic check_result();
        btlv_result_t want;
        if (expected_results.size() == 0) begin
            note_mismatch("result transaction with nothing expected");
            return;
        end
        want = expected_results.pop_front();
        if (m_result_kind !== want.result_kind)
            note_mismatch($sformatf("result_kind %0d, expected %0d",
                m_result_kind, want.result_kind));
        if (m_element_tag !== want.element_tag)
            note_mismatch($sformatf("element_tag %h, expected %h",
                m_element_tag, want.element_tag));
        if (m_value_length !== want.value_length)
            note_mismatch($sformatf("value_length %h, expected %h",
                m_value_length, want.value_length));
        if (m_element_offset !== want.element_offset)
            note_mismatch($sformatf("element_offset %h, expected %h",
                m_element_offset, want.element_offset));
        if (m_value_offset !== want.value_offset)
            note_mismatch($sformatf("value_offset %h, expected %h",
                m_value_offset, want.value_offset));
        if (m_tag_matched !== want.tag_matched)
            note_mismatch($sformatf("tag_matched %0d, expected %0d",
                m_tag_matched, want.tag_matched));
        if (m_scan_status !== want.scan_status)
            note_mismatch($sformatf("scan_status %0d, expected %0d",
                m_scan_status, want.scan_status));
        if (m_last_result !== want.last_result)
            note_mismatch($sformatf("last_result %0d, expected %0d",
                m_last_result, want.last_result));
        if (want.result_kind == KIND_SUMMARY) begin
            summaries_seen++;
            statuses_seen[want.scan_status] = 1'b1;
        end else begin
            elements_seen++;
            if (want.tag_matched) alias_hits++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scan();
            alias_tags     = '{default: 16'h0000};
            alias_count    = MATCH_TAG_COUNT_RESET;
            expected_results.delete();
            errors         = 0;
            elements_seen  = 0;
            alias_hits     = 0;
            summaries_seen = 0;
            statuses_seen  = '0;
        end else begin
            if (m_valid && m_ready) check_result();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MATCH_TAG_COUNT) begin
                    alias_count = cfg_data[2:0];
                end else if (cfg_index < REG_MATCH_TAG_COUNT) begin
                    alias_tags[cfg_index[1:0]] = cfg_data;
                end
            end
            if (s_valid && s_ready) scan_byte(s_data_byte, s_end_of_buffer);
        end
        pending <= expected_results.size();
    end

endmodule

@@ verif/ber_tlv_scanner_tag_finder_tb.sv @@
module ber_tlv_scanner_tag_finder_tb
    import btlv_pkg::*;
;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte     = 8'h00;
    logic        s_end_of_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_result_kind;
    logic [15:0] m_element_tag;
    logic [31:0] m_value_length;
    logic [15:0] m_element_offset;
    logic [15:0] m_value_offset;
    logic        m_tag_matched;
    logic [1:0]  m_scan_status;
    logic        m_last_result;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index       = REG_MATCH_TAG_0;
    logic [15:0] cfg_data        = 16'h0000;

    int          errors;
    int          pending;
    int          elements_seen;
    int          alias_hits;
    int          summaries_seen;
    logic [3:0]  statuses_seen;

    logic        idling     = 1'b1;
    int          stall_left = 0;
    logic [7:0]  buf_bytes [$];
    logic [15:0] alias_now [4];
    int          bytes_sent   = 0;
    int          buffers_sent = 0;
    int          random_bytes = 0;

    ber_tlv_scanner_tag_finder dut (.*);

    btlv_scan_checker scan_check (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result-side backpressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_buffer <= eob;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_buffer();
        int k;
        for (k = 0; k < buf_bytes.size(); k++) begin
            send_byte(buf_bytes[k], k == buf_bytes.size() - 1);
        end
        bytes_sent += buf_bytes.size();
        buffers_sent++;
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_aliases(input logic [2:0] cnt);
        int i;
        wait_quiet();
        for (i = 0; i < 4; i++) begin
            write_reg(3'(REG_MATCH_TAG_0 + i), alias_now[i]);
        end
        // undefined index, must be ignored
        if ($urandom_range(0, 2) == 0) begin
            write_reg(3'(REG_MATCH_TAG_COUNT + $urandom_range(1, 3)),
                      16'($urandom_range(0, 65535)));
        end
        write_reg(REG_MATCH_TAG_COUNT, {13'h0000, cnt});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_alias();
        logic [2:0] hi;
        logic [7:0] lo;
        hi = 3'($urandom_range(0, 7));
        lo = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return {hi, TAG_MORE_MASK, lo};
            default: begin
                if (lo[4:0] == TAG_MORE_MASK) lo[0] = 1'b0;
                return {8'h00, lo};
            end
        endcase
    endfunction

    task automatic emit_tag(input logic [15:0] t);
        if (t[12:8] == TAG_MORE_MASK) begin
            buf_bytes.push_back(t[15:8]);
            buf_bytes.push_back(t[7:0]);
        end else begin
            buf_bytes.push_back(t[7:0]);
            if (t[4:0] == TAG_MORE_MASK) buf_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic int unsigned pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 5);
            6, 7: return $urandom_range(6, 40);
            8: return 0;
            default: return $urandom_range(100, 300);
        endcase
    endfunction

    task automatic emit_length_and_value(input int unsigned len);
        int unsigned rest;
        int          nb;
        int          k;
        if (len < 128 && $urandom_range(0, 2) != 0) begin
            buf_bytes.push_back(8'(len));
        end else begin
            rest = len;
            nb   = 0;
            while (rest != 0) begin
                nb++;
                rest = rest >> 8;
            end
            nb = $urandom_range(nb, MAX_LENGTH_BYTES);
            buf_bytes.push_back(8'(8'h80 | nb));
            for (k = nb - 1; k >= 0; k--) buf_bytes.push_back(8'(len >> (8 * k)));
        end
        for (k = 0; k < len; k++) buf_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // mostly well-formed buffers; some noise, truncated or bad length count
    task automatic make_buffer();
        int n;
        int k;
        int style;
        buf_bytes.delete();
        style = $urandom_range(0, 9);
        if (style == 9) begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) buf_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 2) == 0) emit_tag(alias_now[$urandom_range(0, 3)]);
                else emit_tag(16'($urandom_range(0, 65535)));
                if (style == 7 && k == n - 1) begin
                    buf_bytes.push_back(8'($urandom_range(8'h85, 8'hFF)));
                    repeat ($urandom_range(0, 3)) buf_bytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    emit_length_and_value(pick_length());
                end
            end
            if (style == 8 && buf_bytes.size() > 1) begin
                n = $urandom_range(1, buf_bytes.size() - 1);
                while (buf_bytes.size() > n) void'(buf_bytes.pop_back());
            end
        end
    endtask

    initial begin
        int phase_no;
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed buffers
        alias_now = '{16'h5F2A, 16'h0004, 16'hFFFF, 16'h0000};
        program_aliases(3'd2);
        buf_bytes = '{8'h04, 8'h00};
        send_buffer();
        buf_bytes = '{8'h5F, 8'h2A, 8'h81, 8'h02, 8'hAA, 8'h55, 8'h30, 8'h80};
        send_buffer();
        buf_bytes = '{8'h9F, 8'h85};
        send_buffer();
        buf_bytes = '{8'h01, 8'h85, 8'hFF};
        send_buffer();
        buf_bytes = '{8'h02, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_buffer();
        // match, then buffer ends inside a two-byte tag
        buf_bytes = '{8'h04, 8'h00, 8'h1F};
        send_buffer();

        for (phase_no = 0; phase_no < 8; phase_no++) begin
            for (k = 0; k < 4; k++) alias_now[k] = pick_alias();
            idling <= (phase_no != 3 && phase_no != 7);
            case (phase_no)
                0: program_aliases(3'd0);
                1: program_aliases(3'd4);
                2: program_aliases(3'd7);
                default: program_aliases(3'($urandom_range(0, 7)));
            endcase
            while (random_bytes < (phase_no + 1) * 200) begin
                make_buffer();
                send_buffer();
                random_bytes += buf_bytes.size();
            end
        end

        wait_quiet();
        $display("sent %0d buffers, %0d bytes; checked %0d elements (%0d alias hits)",
                 buffers_sent, bytes_sent, elements_seen, alias_hits);
        $display("%0d buffer summaries, status codes seen (malformed..found) %b",
                 summaries_seen, statuses_seen);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/btlv_pkg.sv
rtl/core/btlv_parser.sv
rtl/core/btlv_result_fifo.sv
rtl/core/ber_tlv_scanner_tag_finder.sv
rtl/core/btlv_checker.sv
verif/btlv_scan_checker.sv
verif/ber_tlv_scanner_tag_finder_tb.sv
